[hdl/chd_pkg.sv]
// Shared types and constants for the chunked body decoder.
`default_nettype none
package chd_pkg;

  localparam int LENGTH_BITS_DEF  = 24;
  localparam int PREFIX_BYTES_DEF = 4;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One result beat from the parser to the output register.
  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] payload;
  } res_t;

endpackage
`default_nettype wire

[hdl/chd_parser.sv]
// Framing state machine: prefix skip, size line, payload count and trailers.
`default_nettype none
module chd_parser #(
  parameter int LENGTH_BITS  = chd_pkg::LENGTH_BITS_DEF,
  parameter int PREFIX_BYTES = chd_pkg::PREFIX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  input  wire logic        first,
  output chd_pkg::res_t    res
);
  import chd_pkg::*;

  typedef enum logic [3:0] {
    PH_PREFIX   = 4'd0,
    PH_SIZE     = 4'd1,
    PH_SIZE_LF  = 4'd2,
    PH_DATA     = 4'd3,
    PH_DATA_CR  = 4'd4,
    PH_DATA_LF  = 4'd5,
    PH_TRAIL_CR = 4'd6,
    PH_TRAIL_LF = 4'd7,
    PH_DONE     = 4'd8,
    PH_ERROR    = 4'd9
  } phase_t;

  localparam phase_t PH_START = (PREFIX_BYTES == 0) ? PH_SIZE : PH_PREFIX;
  localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_BYTES);

  phase_t                 phase_r, phase_nxt, ph_cur;
  logic [2:0]             prefix_r, prefix_nxt, pc_cur, pc_inc;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt, rem_cur;
  logic                   digit_r, digit_nxt, ds_cur;
  logic                   ended_r, ended_nxt, se_cur;
  logic [4:0]             hex;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  always_comb begin
    // a first beat restarts the body before it is parsed
    ph_cur  = first ? PH_START : phase_r;
    pc_cur  = first ? 3'd0 : prefix_r;
    rem_cur = first ? '0 : rem_r;
    ds_cur  = first ? 1'b0 : digit_r;
    se_cur  = first ? 1'b0 : ended_r;

    phase_nxt  = ph_cur;
    prefix_nxt = pc_cur;
    rem_nxt    = rem_cur;
    digit_nxt  = ds_cur;
    ended_nxt  = se_cur;
    hex        = hex_dec(byte_in);
    pc_inc     = pc_cur + 3'd1;
    res        = '{vld: 1'b0, kind: KIND_DATA, payload: 8'd0};

    case (ph_cur)
      PH_PREFIX: begin
        prefix_nxt = pc_inc;
        if (pc_inc >= PREFIX_LAST) phase_nxt = PH_SIZE;
      end
      PH_SIZE: begin
        if (byte_in == CH_CR) begin
          if (!ds_cur) begin
            phase_nxt = PH_ERROR;
            res = '{vld: 1'b1, kind: KIND_ERR, payload: 8'd0};
          end else begin
            phase_nxt = PH_SIZE_LF;
          end
        end else if (!hex[4] || se_cur) begin
          ended_nxt = 1'b1;
        end else if (rem_cur[LENGTH_BITS-1 -: 4] != 4'd0) begin
          phase_nxt = PH_ERROR;
          res = '{vld: 1'b1, kind: KIND_ERR, payload: 8'd0};
        end else begin
          rem_nxt   = {rem_cur[LENGTH_BITS-5:0], hex[3:0]};
          digit_nxt = 1'b1;
        end
      end
      PH_SIZE_LF: begin
        if (byte_in != CH_LF) begin
          phase_nxt = PH_ERROR;
          res = '{vld: 1'b1, kind: KIND_ERR, payload: 8'd0};
        end else begin
          phase_nxt = (rem_cur == '0) ? PH_TRAIL_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        rem_nxt = rem_cur - 1'b1;
        if (rem_cur == LENGTH_BITS'(1)) phase_nxt = PH_DATA_CR;
        res = '{vld: 1'b1, kind: KIND_DATA, payload: byte_in};
      end
      PH_DATA_CR: begin
        if (byte_in != CH_CR) begin
          phase_nxt = PH_ERROR;
          res = '{vld: 1'b1, kind: KIND_ERR, payload: 8'd0};
        end else begin
          phase_nxt = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (byte_in != CH_LF) begin
          phase_nxt = PH_ERROR;
          res = '{vld: 1'b1, kind: KIND_ERR, payload: 8'd0};
        end else begin
          rem_nxt   = '0;
          digit_nxt = 1'b0;
          ended_nxt = 1'b0;
          phase_nxt = PH_SIZE;
        end
      end
      PH_TRAIL_CR: begin
        if (byte_in != CH_CR) begin
          phase_nxt = PH_ERROR;
          res = '{vld: 1'b1, kind: KIND_ERR, payload: 8'd0};
        end else begin
          phase_nxt = PH_TRAIL_LF;
        end
      end
      PH_TRAIL_LF: begin
        phase_nxt = PH_ERROR;
        res = '{vld: 1'b1, kind: KIND_ERR, payload: 8'd0};
        if (byte_in == CH_LF) begin
          phase_nxt = PH_DONE;
          res = '{vld: 1'b1, kind: KIND_DONE, payload: 8'd0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      prefix_r <= 3'd0;
      rem_r    <= '0;
      digit_r  <= 1'b0;
      ended_r  <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      prefix_r <= prefix_nxt;
      rem_r    <= rem_nxt;
      digit_r  <= digit_nxt;
      ended_r  <= ended_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/chd_out_reg.sv]
// Result register driving the master-side stream.
`default_nettype none
module chd_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  chd_pkg::res_t      res,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,   // [7:0] payload
  output logic [1:0]         out_tuser    // [1:0] kind
);
  import chd_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  kind_t      kind_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) vld_nxt = res.vld;
    else if (out_tready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

  // hold payload until the beat is taken
  always_ff @(posedge clk) begin
    if (load && res.vld) begin
      data_r <= res.payload;
      kind_r <= res.kind;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;

endmodule
`default_nettype wire

[hdl/http_chunked_body_decoder_top.sv]
// Top level: HTTP chunked body decoder, one byte beat per cycle while the output is not stalled.
// An accepted input beat passes through the input register, then the parser, then the result
// register. Throughput: one byte per cycle unless out_tready stalls the result register; the
// parser updates its state on the registered byte. Reset (rst_n low, synchronous) empties
// both registers and puts the parser at the start of a body.
`default_nettype none
module http_chunked_body_decoder_top #(
  parameter int LENGTH_BITS  = chd_pkg::LENGTH_BITS_DEF,
  parameter int PREFIX_BYTES = chd_pkg::PREFIX_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] byte_in
  input  wire logic       in_tuser,   // [0] first
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] payload
  output logic [1:0]      out_tuser   // [1:0] kind
);
  import chd_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       adv, step;
  res_t       res;
  res_t       res_gated;

  // result slot free or being emptied this cycle
  assign adv       = !out_tvalid || out_tready;
  assign step      = adv && in_vld_r;
  assign in_tready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tready) in_vld_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else in_vld_r <= in_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser;
    end
  end

  chd_parser #(
    .LENGTH_BITS (LENGTH_BITS),
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .byte_in(byte_r),
    .first  (first_r),
    .res    (res)
  );

  assign res_gated = '{vld: step && res.vld, kind: res.kind, payload: res.payload};

  chd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res_gated),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the HTTP chunked body decoder top level.
`default_nettype none
module testbench;
  import chd_pkg::*;

  localparam int LB = LENGTH_BITS_DEF;
  localparam int PB = PREFIX_BYTES_DEF;
  localparam int ITEM_TARGET = 1130;

  typedef enum logic [3:0] {
    PH_PREFIX, PH_SIZE, PH_SIZE_LF, PH_DATA, PH_DATA_CR, PH_DATA_LF,
    PH_TRAIL_CR, PH_TRAIL_LF, PH_DONE, PH_ERROR
  } parse_phase_t;

  typedef enum int {
    FAULT_NONE, FAULT_NO_DIGITS, FAULT_OVERFLOW, FAULT_SIZE_LF, FAULT_DATA_CR,
    FAULT_DATA_LF, FAULT_TRAIL_CR, FAULT_TRAIL_LF, FAULT_TRUNCATE
  } fault_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
  } beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] byte_in
  logic       in_tuser;   // [0] first
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] payload
  logic [1:0] out_tuser;  // [1:0] kind

  // decoder model state
  parse_phase_t    ph;
  int unsigned     prefix_seen;
  logic [LB-1:0]   remaining;
  bit              digit_seen;
  bit              size_ended;

  beat_t      expected_beats[$];
  logic [7:0] body_q[$];

  int  err_count;
  int  items_sent;
  int  bodies_sent;
  int  data_seen;
  int  done_seen;
  int  error_seen;
  int  hold_off;
  bit  quiet;

  http_chunked_body_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout: handshake stalled");
    $display("testbench: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    err_count++;
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
    if (d < 10) return 8'h30 + d;
    return (upper ? 8'h41 : 8'h61) + d - 8'd10;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  function automatic logic [7:0] any_nonhex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || hex_digit(b) >= 0);
    return b;
  endfunction

  function automatic int pick_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  task automatic restart_body();
    prefix_seen = 0;
    remaining   = '0;
    digit_seen  = 1'b0;
    size_ended  = 1'b0;
    ph          = (PB == 0) ? PH_SIZE : PH_PREFIX;
  endtask

  task automatic push_result(input kind_t k, input logic [7:0] d);
    beat_t r;
    r.kind    = k;
    r.payload = d;
    expected_beats.push_back(r);
  endtask

  task automatic flag_error();
    ph = PH_ERROR;
    push_result(KIND_ERR, 8'h00);
  endtask

  // Advance the decoder model by one accepted byte.
  task automatic decode_byte(input logic [7:0] b, input logic f);
    int hv;
    if (f) restart_body();
    hv = hex_digit(b);
    case (ph)
      PH_PREFIX: begin
        prefix_seen = (prefix_seen + 1) % 8;
        if (prefix_seen >= PB) ph = PH_SIZE;
      end
      PH_SIZE: begin
        if (b == CH_CR) begin
          if (!digit_seen) flag_error();
          else ph = PH_SIZE_LF;
        end else if (hv < 0 || size_ended) begin
          size_ended = 1'b1;
        end else if (remaining[LB-1 -: 4] != 0) begin
          flag_error();
        end else begin
          remaining  = {remaining[LB-5:0], 4'(hv)};
          digit_seen = 1'b1;
        end
      end
      PH_SIZE_LF: begin
        if (b != CH_LF) flag_error();
        else ph = (remaining == 0) ? PH_TRAIL_CR : PH_DATA;
      end
      PH_DATA: begin
        remaining = remaining - 1'b1;
        if (remaining == 0) ph = PH_DATA_CR;
        push_result(KIND_DATA, b);
      end
      PH_DATA_CR: begin
        if (b != CH_CR) flag_error();
        else ph = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (b != CH_LF) begin
          flag_error();
        end else begin
          remaining  = '0;
          digit_seen = 1'b0;
          size_ended = 1'b0;
          ph         = PH_SIZE;
        end
      end
      PH_TRAIL_CR: begin
        if (b != CH_CR) flag_error();
        else ph = PH_TRAIL_LF;
      end
      PH_TRAIL_LF: begin
        if (b != CH_LF) begin
          flag_error();
        end else begin
          ph = PH_DONE;
          push_result(KIND_DONE, 8'h00);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [7:0] b, input logic f);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, f);
    items_sent++;
  endtask

  task automatic send_body(input bit with_first);
    for (int i = 0; i < body_q.size(); i++) send_beat(body_q[i], with_first && i == 0);
    body_q.delete();
    bodies_sent++;
  endtask

  task automatic add_prefix();
    repeat (PB) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_digits(input int unsigned n);
    int nd;
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) body_q.push_back("0");
    for (int i = nd - 1; i >= 0; i--)
      body_q.push_back(hex_char(4'(n >> (4 * i)), 1'($urandom_range(0, 1))));
  endtask

  // Extension bytes: anything but CR, bare LF and later hex digits included.
  task automatic add_extension();
    logic [7:0] b;
    body_q.push_back(any_nonhex());
    repeat ($urandom_range(0, 5)) begin
      b = other_than(CH_CR);
      body_q.push_back(b);
    end
  endtask

  task automatic add_size_line(input int unsigned n);
    add_digits(n);
    if ($urandom_range(0, 3) == 0) add_extension();
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
  endtask

  task automatic add_payload(input int n);
    repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_chunk(input int n);
    add_size_line(n);
    add_payload(n);
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
  endtask

  task automatic build_body(input fault_t fault);
    int n;
    add_prefix();
    repeat ($urandom_range(0, fault == FAULT_NONE ? 3 : 2)) add_chunk(pick_size());
    n = pick_size();
    case (fault)
      FAULT_NONE: add_size_line(0);
      FAULT_NO_DIGITS: begin
        repeat ($urandom_range(0, 3)) body_q.push_back(any_nonhex());
        body_q.push_back(CH_CR);
      end
      FAULT_OVERFLOW: begin
        add_digits($urandom_range(1, 15) << 20 | $urandom_range(0, 20'hFFFFF));
        body_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      FAULT_SIZE_LF: begin
        add_digits(n);
        body_q.push_back(CH_CR);
        body_q.push_back(other_than(CH_LF));
      end
      FAULT_DATA_CR: begin
        add_size_line(n);
        add_payload(n);
        body_q.push_back(other_than(CH_CR));
      end
      FAULT_DATA_LF: begin
        add_size_line(n);
        add_payload(n);
        body_q.push_back(CH_CR);
        body_q.push_back(other_than(CH_LF));
      end
      FAULT_TRAIL_CR: begin
        add_size_line(0);
        body_q.push_back(other_than(CH_CR));
      end
      FAULT_TRAIL_LF: begin
        add_size_line(0);
        body_q.push_back(CH_CR);
        body_q.push_back(other_than(CH_LF));
      end
      default: begin
        // cut off inside a large chunk; the next body restarts the parser
        add_size_line($urandom_range(0, 7) == 0 ? 24'hFFFFFF : $urandom_range(256, 24'hFFFFFF));
        add_payload($urandom_range(0, 6));
      end
    endcase
    if (fault == FAULT_NONE) begin
      body_q.push_back(CH_CR);
      body_q.push_back(CH_LF);
    end
    // trailing bytes after completion or error are dropped by the block
    if (fault != FAULT_TRUNCATE) repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    // no first flag straight after reset: prefix, size with extension and bare LF
    body_q = '{8'h00, 8'hFF, CH_CR, CH_LF, "1", ";", CH_LF, "F", CH_CR, CH_LF,
               8'hFF, CH_CR, CH_LF, "0", CH_CR, CH_LF, CH_CR, CH_LF, 8'h41};
    send_body(1'b0);
    // size line with no digits, then a dropped byte
    body_q = '{8'hA5, 8'h5A, 8'h0F, 8'hF0, CH_CR, 8'h30};
    send_body(1'b1);
  endtask

  task automatic test_random_bodies();
    fault_t fault;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 70) fault = FAULT_NONE;
      else fault = fault_t'($urandom_range(FAULT_NO_DIGITS, FAULT_TRUNCATE));
      build_body(fault);
      send_body(1'b1);
    end
  endtask

  task automatic test_output_stall();
    hold_off = 300;
    add_prefix();
    add_chunk(40);
    add_chunk(40);
    add_size_line(0);
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
    send_body(1'b1);
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (8) begin
      build_body($urandom_range(0, 2) == 0 ? fault_t'($urandom_range(FAULT_NO_DIGITS, FAULT_TRUNCATE))
                                             : FAULT_NONE);
      send_body(1'b1);
    end
    quiet = 1'b0;
  endtask

  // output side: random stall before each beat, or a long hold-off on request
  initial begin
    int n;
    wait (rst_n);
    forever begin
      if (hold_off != 0) begin
        n = hold_off;
        hold_off = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 12);
      end
      if (n != 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : check_results
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d payload %02h", out_tuser, out_tdata));
      end else begin
        want = expected_beats.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_tuser, want.kind));
        if (out_tdata !== want.payload)
          report_mismatch($sformatf("payload %02h, want %02h", out_tdata, want.payload));
        case (want.kind)
          KIND_DATA: data_seen++;
          KIND_DONE: done_seen++;
          default:   error_seen++;
        endcase
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    err_count   = 0;
    items_sent  = 0;
    bodies_sent = 0;
    data_seen   = 0;
    done_seen   = 0;
    error_seen  = 0;
    hold_off    = 0;
    quiet       = 1'b0;
    restart_body();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_bodies();
    test_output_stall();
    test_back_to_back();
    in_tvalid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d bodies, %0d input bytes", bodies_sent, items_sent);
    $display("checked %0d payload, %0d complete, %0d error beats", data_seen, done_seen,
             error_seen);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
